// ===== sv/lpbl_pkg.sv =====
package lpbl_pkg;

   localparam int MAX_LIMIT = 65536;
   localparam int LIMIT_W   = 17;
   localparam int PRIME_W   = 16;
   localparam int ADDR_W    = $clog2(MAX_LIMIT);
   localparam int N_W       = $clog2(MAX_LIMIT + 1);
   localparam int BASE_W    = ADDR_W / 2 + 1;
   localparam int SQ_W      = 2 * BASE_W;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CHK,
      ST_CLR,
      ST_BINIT,
      ST_BSQ,
      ST_BTEST,
      ST_BFLAG,
      ST_STRIKE,
      ST_BNEXT,
      ST_SINIT,
      ST_SREAD,
      ST_STEST,
      ST_DONE
   } step_type;

   typedef enum logic [2:0] {
      COND_ALWAYS,
      COND_NOSTART,
      COND_NLE2,
      COND_CLR_MORE,
      COND_SQ_GE_N,
      COND_FLAG,
      COND_STRIKE_MORE
   } cond_type;

   typedef enum logic [2:0] {
      K_HOLD,
      K_TWO,
      K_INC,
      K_ADD_BASE,
      K_SQ,
      K_NM1,
      K_DEC
   } k_op_type;

   typedef enum logic [1:0] {
      BASE_HOLD,
      BASE_TWO,
      BASE_INC
   } base_op_type;

   typedef enum logic [1:0] {
      BEST_HOLD,
      BEST_ZERO,
      BEST_K
   } best_op_type;

   typedef enum logic {
      RD_BASE,
      RD_K
   } rd_sel_type;

   typedef struct packed {
      cond_type    cond;
      step_type    target;
      k_op_type    k_op;
      base_op_type base_op;
      best_op_type best_op;
      rd_sel_type  rd_sel;
      logic        n_load;
      logic        sq_load;
      logic        wr_en;
      logic        wr_val;
      logic        rd_en;
      logic        emit;
   } ctrl_type;

   typedef struct packed {
      logic nle2;
      logic clr_more;
      logic sq_ge_n;
      logic flag;
      logic strike_more;
   } status_type;

   function automatic ctrl_type ucode(input step_type step);
      ctrl_type w;
      w = '{cond: COND_ALWAYS, target: ST_IDLE, k_op: K_HOLD, base_op: BASE_HOLD,
            best_op: BEST_HOLD, rd_sel: RD_BASE, n_load: 1'b0, sq_load: 1'b0,
            wr_en: 1'b0, wr_val: 1'b0, rd_en: 1'b0, emit: 1'b0};
      unique case (step)
         ST_IDLE: begin
            w.n_load = 1'b1;
            w.cond   = COND_NOSTART;
            w.target = ST_IDLE;
         end
         ST_CHK: begin
            w.k_op    = K_TWO;
            w.best_op = BEST_ZERO;
            w.cond    = COND_NLE2;
            w.target  = ST_DONE;
         end
         ST_CLR: begin
            w.wr_en  = 1'b1;
            w.wr_val = 1'b0;
            w.k_op   = K_INC;
            w.cond   = COND_CLR_MORE;
            w.target = ST_CLR;
         end
         ST_BINIT: begin
            w.base_op = BASE_TWO;
            w.cond    = COND_ALWAYS;
            w.target  = ST_BSQ;
         end
         ST_BSQ: begin
            w.sq_load = 1'b1;
            w.rd_en   = 1'b1;
            w.rd_sel  = RD_BASE;
            w.cond    = COND_ALWAYS;
            w.target  = ST_BTEST;
         end
         ST_BTEST: begin
            w.k_op   = K_SQ;
            w.cond   = COND_SQ_GE_N;
            w.target = ST_SINIT;
         end
         ST_BFLAG: begin
            w.cond   = COND_FLAG;
            w.target = ST_BNEXT;
         end
         ST_STRIKE: begin
            w.wr_en  = 1'b1;
            w.wr_val = 1'b1;
            w.k_op   = K_ADD_BASE;
            w.cond   = COND_STRIKE_MORE;
            w.target = ST_STRIKE;
         end
         ST_BNEXT: begin
            w.base_op = BASE_INC;
            w.cond    = COND_ALWAYS;
            w.target  = ST_BSQ;
         end
         ST_SINIT: begin
            w.k_op   = K_NM1;
            w.cond   = COND_ALWAYS;
            w.target = ST_SREAD;
         end
         ST_SREAD: begin
            w.rd_en  = 1'b1;
            w.rd_sel = RD_K;
            w.cond   = COND_ALWAYS;
            w.target = ST_STEST;
         end
         ST_STEST: begin
            // latch every candidate; the last one checked is the answer
            w.best_op = BEST_K;
            w.k_op    = K_DEC;
            w.cond    = COND_FLAG;
            w.target  = ST_SREAD;
         end
         ST_DONE: begin
            w.emit   = 1'b1;
            w.cond   = COND_ALWAYS;
            w.target = ST_IDLE;
         end
         default: begin
            w.cond   = COND_ALWAYS;
            w.target = ST_IDLE;
         end
      endcase
      return w;
   endfunction

endpackage

// ===== sv/lpbl_ram.sv =====
module lpbl_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 65536
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/lpbl_seq.sv =====
module lpbl_seq (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  lpbl_pkg::status_type status,
   output lpbl_pkg::ctrl_type   ctrl,
   output logic                busy
);
   import lpbl_pkg::*;

   step_type pc_ff;
   step_type pc_in;
   logic     take;

   assign ctrl = ucode(pc_ff);
   assign busy = (pc_ff != ST_IDLE);

   always_comb begin
      unique case (ctrl.cond)
         COND_ALWAYS:      take = 1'b1;
         COND_NOSTART:     take = !start;
         COND_NLE2:        take = status.nle2;
         COND_CLR_MORE:    take = status.clr_more;
         COND_SQ_GE_N:     take = status.sq_ge_n;
         COND_FLAG:        take = status.flag;
         COND_STRIKE_MORE: take = status.strike_more;
         default:          take = 1'b1;
      endcase
      pc_in = take ? ctrl.target : step_type'(pc_ff + 4'd1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= ST_IDLE;
      end else begin
         pc_ff <= pc_in;
      end
   end

   ap_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (pc_ff == ST_CHK))
      else $error("accepted transfer did not enter the program");
   ap_done_returns_idle: assert property (@(posedge clock) disable iff (reset)
      (pc_ff == ST_DONE) |=> (pc_ff == ST_IDLE))
      else $error("done step did not return to idle");

endmodule

// ===== sv/lpbl_dp.sv =====
module lpbl_dp (
   input  logic                        clock,
   input  logic                        reset,
   input  lpbl_pkg::ctrl_type          ctrl,
   input  logic [lpbl_pkg::LIMIT_W-1:0] limit,
   output lpbl_pkg::status_type        status,
   output logic                        rsp_valid,
   output logic [lpbl_pkg::PRIME_W-1:0] rsp_prime
);
   import lpbl_pkg::*;

   logic [N_W-1:0]    n_ff, n_in;
   logic [N_W-1:0]    k_ff, k_in;
   logic [N_W-1:0]    best_ff, best_in;
   logic [BASE_W-1:0] base_ff, base_in;
   logic [SQ_W-1:0]   sq_ff;
   logic              rsp_valid_ff;
   logic [N_W:0]      k_plus_one;
   logic [N_W:0]      k_plus_base;
   logic [ADDR_W-1:0] rd_addr;
   logic              flag;

   assign k_plus_one  = {1'b0, k_ff} + (N_W+1)'(1);
   assign k_plus_base = {1'b0, k_ff} + (N_W+1)'(base_ff);

   always_comb begin
      // saturate the limit to the flag store size
      if (32'(limit) > 32'(MAX_LIMIT)) begin
         n_in = N_W'(MAX_LIMIT);
      end else begin
         n_in = N_W'(limit);
      end

      unique case (ctrl.k_op)
         K_HOLD:     k_in = k_ff;
         K_TWO:      k_in = N_W'(2);
         K_INC:      k_in = k_plus_one[N_W-1:0];
         K_ADD_BASE: k_in = k_plus_base[N_W-1:0];
         K_SQ:       k_in = N_W'(sq_ff);
         K_NM1:      k_in = n_ff - N_W'(1);
         K_DEC:      k_in = k_ff - N_W'(1);
         default:    k_in = k_ff;
      endcase

      unique case (ctrl.base_op)
         BASE_HOLD: base_in = base_ff;
         BASE_TWO:  base_in = BASE_W'(2);
         BASE_INC:  base_in = base_ff + BASE_W'(1);
         default:   base_in = base_ff;
      endcase

      unique case (ctrl.best_op)
         BEST_HOLD: best_in = best_ff;
         BEST_ZERO: best_in = '0;
         BEST_K:    best_in = k_ff;
         default:   best_in = best_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (ctrl.n_load) begin
         n_ff <= n_in;
      end
      if (ctrl.sq_load) begin
         sq_ff <= SQ_W'(base_ff) * SQ_W'(base_ff);
      end
      k_ff    <= k_in;
      base_ff <= base_in;
      best_ff <= best_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= ctrl.emit;
      end
   end

   assign rd_addr = (ctrl.rd_sel == RD_K) ? k_ff[ADDR_W-1:0] : ADDR_W'(base_ff);

   lpbl_ram #(
      .WIDTH(1),
      .DEPTH(MAX_LIMIT)
   ) u_flags (
      .clock  (clock),
      .wr_en  (ctrl.wr_en),
      .wr_addr(k_ff[ADDR_W-1:0]),
      .wr_data(ctrl.wr_val),
      .rd_en  (ctrl.rd_en),
      .rd_addr(rd_addr),
      .rd_data(flag)
   );

   assign status.nle2        = (n_ff <= N_W'(2));
   assign status.clr_more    = (k_plus_one < {1'b0, n_ff});
   assign status.sq_ge_n     = (32'(sq_ff) >= 32'(n_ff));
   assign status.flag        = flag;
   assign status.strike_more = (k_plus_base < {1'b0, n_ff});

   assign rsp_valid = rsp_valid_ff;
   assign rsp_prime = PRIME_W'(32'(best_ff));

   ap_strike_above_square: assert property (@(posedge clock) disable iff (reset)
      (ctrl.wr_en && ctrl.wr_val) |-> (k_ff >= N_W'(4) && k_ff < n_ff))
      else $error("strike outside the sieve range");
   ap_clear_in_range: assert property (@(posedge clock) disable iff (reset)
      (ctrl.wr_en && !ctrl.wr_val) |-> (k_ff >= N_W'(2) && k_ff < n_ff))
      else $error("clear outside the sieve range");

endmodule

// ===== sv/largest_prime_below_limit.sv =====
// Largest prime strictly below req_limit, found with a sieve run by a microcoded sequencer.
// For limit n > 2 it clears the flags below n, strikes the multiples from b*b of each unstruck
// base b with b*b < n, then scans down from n-1 for the first unstruck number; else it answers 0.
// One request at a time: busy holds off the next transfer until the sequencer is idle again.
// rsp_valid pulses for one cycle; the receiver cannot stall. Synchronous reset idles the
// sequencer; the flag RAM needs no clearing since every request rewrites what it reads.
module largest_prime_below_limit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [lpbl_pkg::LIMIT_W-1:0]  req_limit,
   output logic                          rsp_valid,
   output logic [lpbl_pkg::PRIME_W-1:0]  rsp_largest_prime
);
   import lpbl_pkg::*;

   ctrl_type   ctrl;
   status_type status;

   lpbl_seq u_seq (
      .clock (clock),
      .reset (reset),
      .start (start),
      .status(status),
      .ctrl  (ctrl),
      .busy  (busy)
   );

   lpbl_dp u_dp (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (ctrl),
      .limit    (req_limit),
      .status   (status),
      .rsp_valid(rsp_valid),
      .rsp_prime(rsp_largest_prime)
   );

   ap_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe lasted more than one cycle");
   ap_strobe_when_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result shown while a transfer is in progress");

endmodule

// ===== verif/prime_answer_checker.sv =====
`timescale 1ns / 100ps

module prime_answer_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic                                busy,
   input  logic [lpbl_pkg::LIMIT_W-1:0]        req_limit,
   input  logic                                rsp_valid,
   input  logic [lpbl_pkg::PRIME_W-1:0]        rsp_largest_prime,
   output int                                  primes_pending,
   output int                                  failures
);

   import lpbl_pkg::*;

   // one flag per number, set once the sieve proves it composite
   bit                 composite_marks [MAX_LIMIT];
   logic [PRIME_W-1:0] expected_primes [$];

   function automatic logic [PRIME_W-1:0] largest_prime_below(input logic [LIMIT_W-1:0] limit);
      int unsigned        n;
      int unsigned        base;
      int unsigned        k;
      logic [PRIME_W-1:0] best;
      // saturate to the size of the flag store
      n    = (limit > MAX_LIMIT) ? MAX_LIMIT : limit;
      best = '0;
      if (n > 2) begin
         for (k = 2; k < n; k++)
            composite_marks[k] = 1'b0;
         for (base = 2; base * base < n; base++) begin
            if (!composite_marks[base]) begin
               for (k = base * base; k < n; k += base)
                  composite_marks[k] = 1'b1;
            end
         end
         // 2 is never struck, so the scan always stops
         for (k = n - 1; k >= 2; k--) begin
            if (!composite_marks[k]) begin
               best = k[PRIME_W-1:0];
               break;
            end
         end
      end
      return best;
   endfunction

   always @(posedge clock) begin
      logic [PRIME_W-1:0] want;
      if (reset) begin
         expected_primes.delete();
         primes_pending <= 0;
         failures       <= 0;
      end else begin
         // retire the result first: it always belongs to an earlier transfer
         if (rsp_valid) begin
            if (expected_primes.size() == 0) begin
               $error("largest_prime: unexpected transfer, actual %0d", rsp_largest_prime);
               failures <= failures + 1;
            end else begin
               want = expected_primes.pop_front();
               if (rsp_largest_prime !== want) begin
                  $error("largest_prime: expected %0d, actual %0d", want, rsp_largest_prime);
                  failures <= failures + 1;
               end
            end
         end
         if (start && !busy)
            expected_primes.push_back(largest_prime_below(req_limit));
         primes_pending <= expected_primes.size();
      end
   end

endmodule

// ===== verif/tb_largest_prime_below_limit.sv =====
`timescale 1ns / 100ps

module tb_largest_prime_below_limit;

   import lpbl_pkg::*;

   logic               clock     = 1'b0;
   logic               reset     = 1'b1;
   logic               start     = 1'b0;
   logic [LIMIT_W-1:0] req_limit = '0;
   logic               busy;
   logic               rsp_valid;
   logic [PRIME_W-1:0] rsp_largest_prime;
   int                 primes_pending;
   int                 failures;

   largest_prime_below_limit dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_limit         (req_limit),
      .rsp_valid         (rsp_valid),
      .rsp_largest_prime (rsp_largest_prime)
   );

   prime_answer_checker checker_i (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_limit         (req_limit),
      .rsp_valid         (rsp_valid),
      .rsp_largest_prime (rsp_largest_prime),
      .primes_pending    (primes_pending),
      .failures          (failures)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // hold start high until the block takes the transfer
   task automatic send_limit(input logic [LIMIT_W-1:0] value);
      req_limit <= value;
      start     <= 1'b1;
      do @(posedge clock); while (busy);
   endtask

   task automatic drain_results();
      start <= 1'b0;
      do @(posedge clock); while (primes_pending != 0);
   endtask

   initial begin
      logic [LIMIT_W-1:0] directed_limits [$];
      logic [LIMIT_W-1:0] value;
      int unsigned        burst_left;
      int unsigned        band;
      int                 i;

      // tiny limits, squares of primes, powers of two, the largest unsaturated limit and a saturating one
      directed_limits = '{0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11, 12, 13, 17, 24, 25, 49,
                          121, 127, 128, 1024, 65536, 131071};
      burst_left = 0;

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      for (i = 0; i < 100; i++) begin
         if (i < directed_limits.size()) begin
            value = directed_limits[i];
         end else begin
            // keep most limits small so the sieve stays short
            band = $urandom_range(99);
            if (band < 70)
               value = LIMIT_W'($urandom_range(300));
            else if (band < 95)
               value = LIMIT_W'($urandom_range(2000));
            else
               value = LIMIT_W'($urandom_range(8000));
         end
         send_limit(value);

         if (i == directed_limits.size() - 1 || $urandom_range(19) == 0) begin
            drain_results();
         end else if (burst_left == 0) begin
            burst_left = $urandom_range(1, 8);
            start     <= 1'b0;
            req_limit <= LIMIT_W'($urandom);
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end else begin
            burst_left--;
         end
      end

      drain_results();
      repeat (50) @(posedge clock);
      if (failures == 0 && primes_pending == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

   initial begin
      #50_000_000;
      $display("TB_ERROR");
      $finish;
   end

endmodule
